// ===== rtl/srsw_pkg.sv =====
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int WINDOW_MAX    = 16;
    localparam int SLOT_BITS     = $clog2(WINDOW_MAX);
    localparam int OCC_BITS      = SLOT_BITS + 1;
    localparam int COUNT_BITS    = 16;
    localparam int SEQ_BITS      = 6;
    localparam int WSIZE_BITS    = 5;
    localparam int OP_BITS       = 2;
    localparam int KIND_BITS     = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [OCC_BITS-1:0]   t_occ;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [SEQ_BITS-1:0]   t_seq;

    typedef struct packed {
        t_seq   seq;
        t_count index;
    } t_entry;

    typedef enum logic [OP_BITS-1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NEW    = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_SIZE   = 1'b0,
        CFG_TOTAL_PACKETS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRONT_CHK,
        S_POP,
        S_CALC,
        S_SCAN,
        S_RESEND,
        S_LOAD,
        S_STATUS
    } t_state;

    // A window size of zero acts as one, and anything above the maximum acts as the maximum.
    function automatic logic [WSIZE_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] w);
        logic [WSIZE_BITS-1:0] r;
        r = w;
        if (w == '0) begin
            r = WSIZE_BITS'(1);
        end else if (w > WSIZE_BITS'(WINDOW_MAX)) begin
            r = WSIZE_BITS'(WINDOW_MAX);
        end
        return r;
    endfunction

    // Sequence numbers run from one to twice the window plus one, then wrap to one.
    function automatic t_seq bump_seq(input t_seq seq, input logic [WSIZE_BITS-1:0] eff);
        t_seq nxt;
        t_seq lim;
        nxt = seq + 1'b1;
        lim = SEQ_BITS'({eff, 1'b1});
        if (nxt > lim) begin
            nxt = SEQ_BITS'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/selective_repeat_send_window.sv =====
`timescale 1ns / 1ps

// Sender side of a selective-repeat sliding window that issues sequence numbers only.
// A command is taken when start is high and busy is low; operation selects a transfer
// start, a received ack carrying ack_seq, or a timeout. Each command produces one or
// more results, each shown for exactly one cycle with o_res_strobe high, the final one
// marked by o_last. The receiver cannot stall, so results are never held back.
// A start loads up to sixteen packets into the window.
// A timeout walks the window one entry per cycle through the entry memory read port,
// resending each entry not yet acked and ending with the last such entry.
// An ack whose number matches the front entry marks it acked, pops the acked entries
// from the front, sizes the refill and then loads the new packets. An ack that does
// not match the front entry scans the window for its number before sizing the refill.
// Commands that send nothing give a single status result.
// The window memory has one write port and one registered read port; the acked flags
// are held in flip-flops. Configuration writes are taken in any cycle, and are
// expected only while the block is idle.
// Reset clears the window, the counters and the done flag, and sets the window size
// register to one and the packet total to zero.

module selective_repeat_send_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [srsw_pkg::OP_BITS-1:0]        i_operation,
    input  logic [srsw_pkg::SEQ_BITS-1:0]       i_ack_seq,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [srsw_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [srsw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                                o_res_strobe,
    output logic [srsw_pkg::KIND_BITS-1:0]      o_kind,
    output logic [srsw_pkg::SEQ_BITS-1:0]       o_send_seq,
    output logic [srsw_pkg::COUNT_BITS-1:0]     o_packet_index,
    output logic [srsw_pkg::OCC_BITS-1:0]       o_window_count,
    output logic [srsw_pkg::COUNT_BITS-1:0]     o_acked_total,
    output logic                                o_done_res,
    output logic                                o_last
);

    import srsw_pkg::*;

    t_state                  r_state, n_state;
    t_slot                   r_head, n_head;
    t_occ                    r_occ, n_occ;
    t_seq                    r_next_seq, n_next_seq;
    t_count                  r_loaded, n_loaded;
    t_count                  r_acked, n_acked;
    logic                    r_done, n_done;
    logic [WINDOW_MAX-1:0]   r_acked_v, n_acked_v;
    logic [WSIZE_BITS-1:0]   r_win_size, n_win_size;
    t_count                  r_total, n_total;

    t_seq                    r_ack, n_ack;
    t_occ                    r_pos, n_pos;
    t_occ                    r_cnt, n_cnt;
    t_occ                    r_pops, n_pops;
    t_occ                    r_fin_occ, n_fin_occ;
    logic                    r_rd_vld, n_rd_vld;
    t_occ                    r_rd_pos, n_rd_pos;
    logic [WINDOW_MAX-1:0]   r_umask, n_umask;

    logic                    r_out_strobe, n_out_strobe;
    t_kind                   r_out_kind, n_out_kind;
    t_seq                    r_out_seq, n_out_seq;
    t_count                  r_out_idx, n_out_idx;
    t_occ                    r_out_occ, n_out_occ;
    t_count                  r_out_acked, n_out_acked;
    logic                    r_out_done, n_out_done;
    logic                    r_out_last, n_out_last;

    t_entry                  r_mem [WINDOW_MAX];
    t_entry                  r_rd_data;
    logic                    mem_we;
    t_slot                   mem_waddr;
    t_entry                  mem_wdata;
    t_slot                   rd_addr;

    logic [WSIZE_BITS-1:0]   eff;
    t_occ                    start_n;
    t_count                  acked_inc;
    t_count                  diff;
    t_occ                    nload;
    t_slot                   issue_slot;
    t_slot                   proc_slot;
    t_slot                   load_slot;
    logic                    issue;
    logic [WINDOW_MAX-1:0]   umask_now;
    logic [WINDOW_MAX-1:0]   umask_left;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_res_strobe   = r_out_strobe;
    assign o_kind         = r_out_kind;
    assign o_send_seq     = r_out_seq;
    assign o_packet_index = r_out_idx;
    assign o_window_count = r_out_occ;
    assign o_acked_total  = r_out_acked;
    assign o_done_res     = r_out_done;
    assign o_last         = r_out_last;

    assign eff        = eff_window(r_win_size);
    assign start_n    = (r_total < COUNT_BITS'(eff)) ? OCC_BITS'(r_total) : OCC_BITS'(eff);
    assign acked_inc  = (r_acked < r_total) ? r_acked + 1'b1 : r_acked;
    assign diff       = r_total - r_loaded;
    assign issue_slot = r_head + r_pos[SLOT_BITS-1:0];
    assign proc_slot  = r_head + r_rd_pos[SLOT_BITS-1:0];
    assign load_slot  = r_head + r_occ[SLOT_BITS-1:0];
    assign issue      = (r_pos < r_occ);
    assign rd_addr    = (r_state == S_IDLE) ? r_head : issue_slot;

    always_comb begin
        if (r_loaded < r_total) begin
            nload = (diff < COUNT_BITS'(r_pops)) ? OCC_BITS'(diff) : r_pops;
        end else begin
            nload = '0;
        end
    end

    always_comb begin
        for (int p = 0; p < WINDOW_MAX; p++) begin
            umask_now[p] = (OCC_BITS'(p) < r_occ) && !r_acked_v[r_head + SLOT_BITS'(p)];
        end
    end

    always_comb begin
        umask_left = r_umask;
        umask_left[r_rd_pos[SLOT_BITS-1:0]] = 1'b0;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_occ        = r_occ;
        n_next_seq   = r_next_seq;
        n_loaded     = r_loaded;
        n_acked      = r_acked;
        n_done       = r_done;
        n_acked_v    = r_acked_v;
        n_win_size   = r_win_size;
        n_total      = r_total;
        n_ack        = r_ack;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_pops       = r_pops;
        n_fin_occ    = r_fin_occ;
        n_rd_vld     = 1'b0;
        n_rd_pos     = r_pos;
        n_umask      = r_umask;
        n_out_strobe = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_seq    = r_out_seq;
        n_out_idx    = r_out_idx;
        n_out_occ    = r_out_occ;
        n_out_acked  = r_out_acked;
        n_out_done   = r_out_done;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = load_slot;
        mem_wdata    = '{seq: r_next_seq, index: r_loaded};

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_SIZE:   n_win_size = i_cfg_data[WSIZE_BITS-1:0];
                CFG_TOTAL_PACKETS: n_total    = i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ack     = i_ack_seq;
                    n_fin_occ = r_occ;
                    n_pos     = '0;
                    unique case (t_op'(i_operation))
                        OP_START: begin
                            n_head     = '0;
                            n_occ      = '0;
                            n_next_seq = SEQ_BITS'(1);
                            n_loaded   = '0;
                            n_acked    = '0;
                            n_done     = (r_total == '0);
                            n_acked_v  = '0;
                            n_cnt      = start_n;
                            n_fin_occ  = start_n;
                            n_state    = (start_n == '0) ? S_STATUS : S_LOAD;
                        end
                        OP_ACK: begin
                            n_state = (r_done || r_occ == '0) ? S_STATUS : S_FRONT_CHK;
                        end
                        OP_TIMEOUT: begin
                            n_umask = umask_now;
                            n_state = (umask_now == '0) ? S_STATUS : S_RESEND;
                        end
                        default: n_state = S_STATUS;
                    endcase
                end
            end

            S_FRONT_CHK: begin
                n_pops = '0;
                if (r_rd_data.seq == r_ack) begin
                    if (!r_acked_v[r_head]) begin
                        n_acked_v[r_head] = 1'b1;
                        n_acked           = acked_inc;
                    end
                    n_state = S_POP;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_POP: begin
                if (r_occ != '0 && r_acked_v[r_head]) begin
                    n_head = r_head + 1'b1;
                    n_occ  = r_occ - 1'b1;
                    n_pops = r_pops + 1'b1;
                end else begin
                    n_state = S_CALC;
                end
            end

            S_SCAN: begin
                n_rd_vld = issue;
                if (issue) begin
                    n_pos = r_pos + 1'b1;
                end
                if (r_rd_vld && r_rd_data.seq == r_ack && !r_acked_v[proc_slot]) begin
                    n_acked_v[proc_slot] = 1'b1;
                    n_acked              = acked_inc;
                end
                if (!issue && !r_rd_vld) begin
                    n_state = S_CALC;
                end
            end

            S_CALC: begin
                if (r_acked >= r_total) begin
                    n_done    = 1'b1;
                    n_head    = '0;
                    n_occ     = '0;
                    n_acked_v = '0;
                    n_state   = S_STATUS;
                end else begin
                    n_cnt     = nload;
                    n_fin_occ = r_occ + nload;
                    n_state   = (nload == '0) ? S_STATUS : S_LOAD;
                end
            end

            S_LOAD: begin
                mem_we               = 1'b1;
                n_acked_v[load_slot] = 1'b0;
                n_occ                = r_occ + 1'b1;
                n_loaded             = r_loaded + 1'b1;
                n_next_seq           = bump_seq(r_next_seq, eff);
                n_cnt                = r_cnt - 1'b1;
                n_out_strobe         = 1'b1;
                n_out_kind           = KIND_NEW;
                n_out_seq            = r_next_seq;
                n_out_idx            = r_loaded;
                n_out_occ            = r_fin_occ;
                n_out_acked          = r_acked;
                n_out_done           = r_done;
                n_out_last           = (r_cnt == OCC_BITS'(1));
                if (r_cnt == OCC_BITS'(1)) begin
                    n_state = S_IDLE;
                end
            end

            S_RESEND: begin
                n_rd_vld = issue;
                if (issue) begin
                    n_pos = r_pos + 1'b1;
                end
                if (r_rd_vld && r_umask[r_rd_pos[SLOT_BITS-1:0]]) begin
                    n_umask      = umask_left;
                    n_out_strobe = 1'b1;
                    n_out_kind   = KIND_RESEND;
                    n_out_seq    = r_rd_data.seq;
                    n_out_idx    = r_rd_data.index;
                    n_out_occ    = r_occ;
                    n_out_acked  = r_acked;
                    n_out_done   = r_done;
                    n_out_last   = (umask_left == '0);
                    if (umask_left == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_STATUS: begin
                n_out_strobe = 1'b1;
                n_out_kind   = KIND_STATUS;
                n_out_seq    = '0;
                n_out_idx    = '0;
                n_out_occ    = r_occ;
                n_out_acked  = r_acked;
                n_out_done   = r_done;
                n_out_last   = 1'b1;
                n_state      = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_occ        <= '0;
            r_next_seq   <= SEQ_BITS'(1);
            r_loaded     <= '0;
            r_acked      <= '0;
            r_done       <= 1'b0;
            r_acked_v    <= '0;
            r_win_size   <= WSIZE_BITS'(1);
            r_total      <= '0;
            r_rd_vld     <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_occ        <= n_occ;
            r_next_seq   <= n_next_seq;
            r_loaded     <= n_loaded;
            r_acked      <= n_acked;
            r_done       <= n_done;
            r_acked_v    <= n_acked_v;
            r_win_size   <= n_win_size;
            r_total      <= n_total;
            r_rd_vld     <= n_rd_vld;
            r_out_strobe <= n_out_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ack       <= n_ack;
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_pops      <= n_pops;
        r_fin_occ   <= n_fin_occ;
        r_rd_pos    <= n_rd_pos;
        r_umask     <= n_umask;
        r_out_kind  <= n_out_kind;
        r_out_seq   <= n_out_seq;
        r_out_idx   <= n_out_idx;
        r_out_occ   <= n_out_occ;
        r_out_acked <= n_out_acked;
        r_out_done  <= n_out_done;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_BITS'(WINDOW_MAX))
        else $error("Window occupancy exceeds the window depth.");

    a_new_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_strobe && r_out_kind == KIND_NEW) |-> $past(r_state) == S_LOAD)
        else $error("A new-packet result did not come from the load sequence.");

    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_strobe && r_out_last) |-> r_state == S_IDLE)
        else $error("The final result of a transaction left the sequencer busy.");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_done) |-> r_occ == '0)
        else $error("A finished transfer still holds window entries.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("An accepted transaction did not start the sequencer.");

endmodule
